[design/msfd_pkg.sv]
// Shared types, constants and register codes of the multi-server dispatcher.
`default_nettype none
package msfd_pkg;
	localparam int DEF_SERVER_COUNT = 8;
	localparam int DEF_QUEUE_DEPTH = 128;

	localparam logic [0:0] REG_NUM_SERVERS = 1'd0;
	localparam logic [0:0] REG_SERVICE_TIME = 1'd1;

	localparam logic KIND_COMPLETION = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic arrival;
		logic service_only;
	} tick_in_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  server_index;
		logic [15:0] customer_number;
		logic [31:0] finish_tick;
		logic [7:0]  queue_count;
		logic [3:0]  busy_count;
		logic [31:0] completed_total;
		logic [31:0] total_wait;
		logic        arrival_dropped;
		logic        last;
	} tick_out_t;
endpackage
`default_nettype wire

[design/msfd_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module msfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/msfd_front.sv]
// Front part: input queue of tick beats between the port and the engine.
`default_nettype none
module msfd_front import msfd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire tick_in_t in_data,
	output logic          avail,
	input  wire logic     take,
	output tick_in_t      head
);
	tick_in_t  buf_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;
	logic      do_push, do_pop;

	assign full = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign head = buf_q[rp_q];
	assign do_push = push && !full;
	assign do_pop = take && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("front queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |=> !(rp_q != $past(rp_q)))
		else $error("front queue popped while empty");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !take) |=> full)
		else $error("front queue lost an entry");
`endif
endmodule
`default_nettype wire

[design/msfd_engine.sv]
// Back part: sequencer that walks the servers for one tick and emits results.
`default_nettype none
module msfd_engine import msfd_pkg::*; #(
	parameter int SERVER_COUNT = DEF_SERVER_COUNT,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [3:0]  num_servers,
	input  wire logic [15:0] service_time,
	input  wire logic        avail,
	output logic             take,
	input  wire tick_in_t    head,
	output logic             out_valid,
	input  wire logic        out_take,
	output tick_out_t        out_data
);
	localparam int SW = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;
	localparam int CW = $clog2(SERVER_COUNT + 1);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_COUNT = 3'd1;
	localparam logic [2:0] ST_ARR   = 3'd2;
	localparam logic [2:0] ST_DISP  = 3'd3;
	localparam logic [2:0] ST_RDW   = 3'd4;
	localparam logic [2:0] ST_SUM   = 3'd5;

	logic [2:0]  state_q;
	logic [SW-1:0] idx_q;
	tick_in_t    cur_q;
	logic        drop_q;
	logic [CW-1:0] busyc_q;

	logic [SERVER_COUNT-1:0] busy_q;
	logic [15:0] rem_q [SERVER_COUNT];
	logic [15:0] cust_q [SERVER_COUNT];

	logic [QW-1:0] qhead_q, qtail_q;
	logic [FW-1:0] qfill_q;
	logic [31:0] tick_q, wait_q, done_q;
	logic [15:0] ccnt_q;

	logic        ov_q;
	tick_out_t   od_q;

	logic [CW-1:0] active;
	logic          last_idx;
	logic [15:0]   rem_dec;
	logic [15:0]   qrdata;
	logic          qwe;
	logic [15:0]   cnext;
	logic [32:0]   wsum;
	logic [31:0]   wadd;
	logic          stall;
	logic          emit;

	assign active = (int'(num_servers) > SERVER_COUNT) ? CW'(SERVER_COUNT)
		: CW'(num_servers);
	assign last_idx = ({{(CW-SW){1'b0}}, idx_q} + CW'(1)) >= active;
	assign rem_dec = rem_q[idx_q] - 16'd1;
	assign cnext = ccnt_q + 16'd1;
	assign qwe = (state_q == ST_ARR) && cur_q.arrival && (qfill_q != FW'(QUEUE_DEPTH));
	assign wadd = 32'(qfill_q);
	assign wsum = {1'b0, wait_q} + {1'b0, wadd};

	// A new beat is loaded into the output register on a completion or on the summary.
	assign stall = ov_q && !out_take;
	assign emit = !stall && (((state_q == ST_COUNT) && busy_q[idx_q] && (rem_dec == 16'd0)) ||
		((state_q == ST_SUM) && !(active != '0 && !last_idx)));

	assign take = (state_q == ST_IDLE) && avail;
	assign out_valid = ov_q;
	assign out_data = od_q;

	msfd_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .we(qwe), .waddr(qtail_q), .wdata(cnext),
		.raddr(qhead_q), .rdata(qrdata)
	);

	always_ff @(posedge clk) begin
		if (take) cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			drop_q <= 1'b0;
			busyc_q <= '0;
			busy_q <= '0;
			for (int i = 0; i < SERVER_COUNT; i++) begin
				rem_q[i] <= '0;
				cust_q[i] <= '0;
			end
			qhead_q <= '0;
			qtail_q <= '0;
			qfill_q <= '0;
			tick_q <= '0;
			wait_q <= '0;
			done_q <= '0;
			ccnt_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (out_take) ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						tick_q <= tick_q + 32'd1;
						idx_q <= '0;
						drop_q <= 1'b0;
						busyc_q <= '0;
						state_q <= (active == '0) ? ST_ARR : ST_COUNT;
					end
				end
				ST_COUNT: begin
					// Each count step, with or without a completion, needs the output register free before it advances.
					if (!(ov_q && !out_take)) begin
						if (busy_q[idx_q]) begin
							rem_q[idx_q] <= rem_dec;
							if (rem_dec == 16'd0) begin
								busy_q[idx_q] <= 1'b0;
								if (done_q != 32'hFFFF_FFFF) done_q <= done_q + 32'd1;
								od_q <= '{kind: KIND_COMPLETION, server_index: 3'(idx_q),
									customer_number: cust_q[idx_q], finish_tick: tick_q,
									default: '0};
							end
						end
						if (last_idx) begin
							idx_q <= '0;
							state_q <= ST_ARR;
						end else begin
							idx_q <= idx_q + SW'(1);
						end
					end
				end
				ST_ARR: begin
					if (cur_q.service_only) begin
						idx_q <= '0;
						state_q <= ST_SUM;
					end else begin
						if (cur_q.arrival) begin
							ccnt_q <= cnext;
							if (qfill_q == FW'(QUEUE_DEPTH)) begin
								drop_q <= 1'b1;
							end else begin
								qtail_q <= (qtail_q == QW'(QUEUE_DEPTH - 1)) ? '0
									: qtail_q + QW'(1);
								qfill_q <= qfill_q + FW'(1);
							end
						end
						idx_q <= '0;
						state_q <= ST_RDW;
					end
				end
				ST_RDW: begin
					// Lets the queue read settle on the current head address.
					state_q <= (active == '0) ? ST_SUM : ST_DISP;
				end
				ST_DISP: begin
					if (!busy_q[idx_q] && qfill_q != '0) begin
						busy_q[idx_q] <= 1'b1;
						rem_q[idx_q] <= (service_time == 16'd0) ? 16'd1 : service_time;
						cust_q[idx_q] <= qrdata;
						qhead_q <= (qhead_q == QW'(QUEUE_DEPTH - 1)) ? '0
							: qhead_q + QW'(1);
						qfill_q <= qfill_q - FW'(1);
						if (last_idx) begin
							idx_q <= '0;
							state_q <= ST_SUM;
						end else begin
							idx_q <= idx_q + SW'(1);
							state_q <= ST_RDW;
						end
					end else if (last_idx) begin
						idx_q <= '0;
						state_q <= ST_SUM;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				ST_SUM: begin
					// Busy servers are counted one per cycle before the summary.
					if (idx_q < SW'(SERVER_COUNT - 1) || !(ov_q && !out_take) ||
						{{(CW-SW){1'b0}}, idx_q} < active) begin
						if ({{(CW-SW){1'b0}}, idx_q} < active && busy_q[idx_q] &&
							!(last_idx && ov_q && !out_take)) begin
							busyc_q <= busyc_q + CW'(1);
						end
					end
					if (active != '0 && !last_idx) begin
						idx_q <= idx_q + SW'(1);
					end else if (!(ov_q && !out_take)) begin
						od_q <= '{kind: KIND_SUMMARY, server_index: 3'd0,
							customer_number: 16'd0, finish_tick: tick_q,
							queue_count: 8'(qfill_q),
							busy_count: 4'(busyc_q + CW'((active != '0) && busy_q[idx_q])),
							completed_total: done_q,
							total_wait: cur_q.service_only ? wait_q
								: (wsum[32] ? 32'hFFFF_FFFF : wsum[31:0]),
							arrival_dropped: drop_q, last: 1'b1};
						if (!cur_q.service_only) begin
							wait_q <= wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qfill_q <= FW'(QUEUE_DEPTH))
		else $error("queue fill exceeds depth");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_take) |=> (ov_q && $stable(od_q)))
		else $error("waiting result overwritten");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q != ST_IDLE))
		else $error("tick taken without starting");
`endif
endmodule
`default_nettype wire

[design/multi_server_fifo_dispatcher_top.sv]
// Top level: configuration registers, front queue and tick engine.
// Completions leave one per cycle at best, the summary last; output stalls hold the count
// walk and the summary. The engine takes a new tick only once idle, after its three
// server walks (count, dispatch, summary); a service-only tick skips the dispatch walk,
// and a dispatch to a server other than the last in use re-enters the queue read wait.
// Reset: arst_n clears all server, queue and counter state asynchronously;
// registers return to one server and a service time of one.
`default_nettype none
module multi_server_fifo_dispatcher_top import msfd_pkg::*; #(
	parameter int SERVER_COUNT = DEF_SERVER_COUNT,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire tick_in_t    in_data,
	output logic             empty,
	input  wire logic        pop,
	output tick_out_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [3:0]  nserv_q;
	logic [15:0] stime_q;
	logic        avail, take, ovalid;
	tick_in_t    head;
	logic        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nserv_q <= 4'd1;
			stime_q <= 16'd1;
		end else if (wr && paddr[1:0] == 2'd0) begin
			if (paddr[2] == REG_NUM_SERVERS) nserv_q <= pwdata[3:0];
			else stime_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_NUM_SERVERS) prdata = {28'd0, nserv_q};
		else prdata = {16'd0, stime_q};
	end

	msfd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.avail(avail), .take(take), .head(head)
	);

	msfd_engine #(.SERVER_COUNT(SERVER_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .num_servers(nserv_q), .service_time(stime_q),
		.avail(avail), .take(take), .head(head),
		.out_valid(ovalid), .out_take(pop), .out_data(out_data)
	);

	assign empty = !ovalid;

`ifndef SYNTH
	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> 1'b1)
		else $error("pop check");
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_data.kind == out_data.last))
		else $error("summary flag mismatch");
`endif
endmodule
`default_nettype wire

[dv/multi_server_fifo_dispatcher_top_test.sv]
// Self-checking testbench for the multi-server dispatcher: scoreboarded ticks and APB setup.
`timescale 1ns / 1ps
`default_nettype none
module multi_server_fifo_dispatcher_top_test;
	import msfd_pkg::*;

	localparam int SERVERS = DEF_SERVER_COUNT;
	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	tick_in_t in_data = '0;
	logic empty;
	logic pop = 1'b0;
	tick_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	multi_server_fifo_dispatcher_top u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.empty(empty), .pop(pop), .out_data(out_data), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Shadow state of the queue simulation.
	logic [3:0] cfg_servers;
	logic [15:0] cfg_service;
	logic srv_busy [SERVERS];
	logic [15:0] srv_left [SERVERS];
	logic [15:0] srv_cust [SERVERS];
	logic [15:0] line_store [DEPTH];
	int line_head, line_tail, line_fill;
	logic [31:0] tick_no, done_total, wait_total;
	logic [15:0] cust_no;

	tick_out_t expected_beats[$];
	int errors = 0;
	longint cycles = 0;
	bit hold_pop = 1'b0;

	function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic predict_tick(tick_in_t t);
		int active;
		int busy;
		logic dropped;
		tick_out_t r;
		active = (cfg_servers > SERVERS) ? SERVERS : cfg_servers;
		busy = 0;
		dropped = 1'b0;
		tick_no = tick_no + 32'd1;
		for (int i = 0; i < active; i++) begin
			if (srv_busy[i]) begin
				srv_left[i] = srv_left[i] - 16'd1;
				if (srv_left[i] == 0) begin
					srv_busy[i] = 1'b0;
					done_total = sat_inc(done_total, 1);
					r = '0;
					r.kind = KIND_COMPLETION;
					r.server_index = i[2:0];
					r.customer_number = srv_cust[i];
					r.finish_tick = tick_no;
					expected_beats.push_back(r);
				end
			end
		end
		if (!t.service_only) begin
			if (t.arrival) begin
				cust_no = cust_no + 16'd1;
				if (line_fill >= DEPTH) begin
					dropped = 1'b1;
				end else begin
					line_store[line_tail] = cust_no;
					line_tail = (line_tail + 1) % DEPTH;
					line_fill++;
				end
			end
			for (int i = 0; i < active && line_fill > 0; i++) begin
				if (!srv_busy[i]) begin
					srv_busy[i] = 1'b1;
					srv_left[i] = (cfg_service == 0) ? 16'd1 : cfg_service;
					srv_cust[i] = line_store[line_head];
					line_head = (line_head + 1) % DEPTH;
					line_fill--;
				end
			end
			wait_total = sat_inc(wait_total, line_fill);
		end
		for (int i = 0; i < active; i++)
			if (srv_busy[i])
				busy++;
		r = '0;
		r.kind = KIND_SUMMARY;
		r.finish_tick = tick_no;
		r.queue_count = line_fill[7:0];
		r.busy_count = busy[3:0];
		r.completed_total = done_total;
		r.total_wait = wait_total;
		r.arrival_dropped = dropped;
		r.last = 1'b1;
		expected_beats.push_back(r);
	endtask

	// push stays high between back-to-back beats and drops only for a gap or a drain.
	task automatic send_tick(logic arrival, logic service_only);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_data <= '{arrival: arrival, service_only: service_only};
		@(posedge clk);
		while (full) @(posedge clk);
		predict_tick('{arrival: arrival, service_only: service_only});
	endtask

	task automatic drain_results();
		push <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == REG_NUM_SERVERS)
			cfg_servers = value[3:0];
		else
			cfg_service = value[15:0];
	endtask

	task automatic configure(logic [31:0] servers, logic [31:0] service);
		drain_results();
		write_reg(REG_NUM_SERVERS, servers);
		write_reg(REG_SERVICE_TIME, service);
	endtask

	// Extremes of the registers, including a zero service time, and every input mix.
	task automatic test_directed();
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
		configure(8, 2);
		repeat (6) send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		configure(15, 0);
		repeat (4) send_tick(1'b1, 1'b0);
		configure(0, 3);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		configure(3, 65535);
		repeat (4) send_tick(1'b1, 1'b0);
	endtask

	// Fill the line past its depth with a single slow server to force drops.
	task automatic test_overflow();
		configure(1, 200);
		repeat (135) send_tick(1'b1, 1'b0);
		configure(8, 1);
		repeat (20) send_tick(1'b0, 1'($urandom_range(0, 1)));
	endtask

	// Random ticks with a long receiver hold-off in the middle.
	task automatic test_random();
		configure($urandom_range(1, 8), $urandom_range(1, 6));
		for (int n = 0; n < 82; n++) begin
			if (n == 30)
				hold_pop = 1'b1;
			if (n == 55) begin
				drain_results();
				configure($urandom_range(0, 15), $urandom_range(0, 5));
			end
			send_tick($urandom_range(0, 99) < 60, $urandom_range(0, 5) == 0);
		end
		drain_results();
	endtask

	// The receiver stalls for a counted stretch while ticks keep coming.
	always begin
		@(posedge clk);
		if (hold_pop) begin
			repeat (400) @(posedge clk);
			hold_pop = 1'b0;
		end
	end

	// The receiver draws a wait before each beat, then holds pop until one is taken.
	initial begin : receiver
		int pause;
		wait (arst_n);
		@(posedge clk);
		forever begin
			pause = $urandom_range(0, 16);
			if (pause != 0 || hold_pop)
				pop <= 1'b0;
			repeat (pause) @(posedge clk);
			while (hold_pop) @(posedge clk);
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		tick_out_t e;
		if (arst_n && pop && !empty) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat kind=%0d", out_data.kind);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (out_data.kind !== e.kind) begin
					$error("kind exp %0d got %0d", e.kind, out_data.kind); errors++;
				end
				if (out_data.server_index !== e.server_index) begin
					$error("server_index exp %0d got %0d", e.server_index,
						out_data.server_index); errors++;
				end
				if (out_data.customer_number !== e.customer_number) begin
					$error("customer_number exp %0d got %0d", e.customer_number,
						out_data.customer_number); errors++;
				end
				if (out_data.finish_tick !== e.finish_tick) begin
					$error("finish_tick exp %0d got %0d", e.finish_tick,
						out_data.finish_tick); errors++;
				end
				if (out_data.queue_count !== e.queue_count) begin
					$error("queue_count exp %0d got %0d", e.queue_count,
						out_data.queue_count); errors++;
				end
				if (out_data.busy_count !== e.busy_count) begin
					$error("busy_count exp %0d got %0d", e.busy_count,
						out_data.busy_count); errors++;
				end
				if (out_data.completed_total !== e.completed_total) begin
					$error("completed_total exp %0d got %0d", e.completed_total,
						out_data.completed_total); errors++;
				end
				if (out_data.total_wait !== e.total_wait) begin
					$error("total_wait exp %0d got %0d", e.total_wait,
						out_data.total_wait); errors++;
				end
				if (out_data.arrival_dropped !== e.arrival_dropped) begin
					$error("arrival_dropped exp %0d got %0d", e.arrival_dropped,
						out_data.arrival_dropped); errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		cfg_servers = 4'd1;
		cfg_service = 16'd1;
		for (int i = 0; i < SERVERS; i++) begin
			srv_busy[i] = 1'b0;
			srv_left[i] = '0;
			srv_cust[i] = '0;
		end
		line_head = 0;
		line_tail = 0;
		line_fill = 0;
		tick_no = '0;
		cust_no = '0;
		done_total = '0;
		wait_total = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_overflow();
		test_random();
		if (errors == 0 && expected_beats.size() == 0)
			$display("[ OK ] regression clean");
		else begin
			if (expected_beats.size() != 0)
				$error("%0d result beats never arrived", expected_beats.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
